@@ design/mmts_pkg.sv @@
// ----------------------------------------------------------------------------
// mmts_pkg
// Shared types and constants for the min/max tracking stack.
// ----------------------------------------------------------------------------
package mmts_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // opcodes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic signed [31:0] push_value;
  } mmts_req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               is_empty;
    logic        [6:0]  entry_count;
    logic        [1:0]  status;
  } mmts_rsp_t;

endpackage

@@ design/mmts_ram.sv @@
// ----------------------------------------------------------------------------
// mmts_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mmts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/min_max_tracking_stack.sv @@
// ----------------------------------------------------------------------------
// min_max_tracking_stack
// LIFO of signed values where each entry carries the running min and max.
// ----------------------------------------------------------------------------
// Each request (push, pop or peek) yields one response with the top value,
// min, max, empty flag, count and status; an empty stack reads -1 in all
// three value fields. The top entry is cached in registers, so push, peek,
// rejected requests and a pop that empties the stack complete in the cycle
// they are accepted. A pop that leaves entries behind waits in S_LOAD for
// the new top from the entry RAM, whose read data is registered. The
// response is registered and shows up the cycle after the work completes.
module min_max_tracking_stack
  import mmts_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  mmts_req_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output mmts_rsp_t rsp_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int EW = 3 * DATA_WIDTH;

  typedef enum logic {S_IDLE, S_LOAD} state_t;

  state_t state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic signed [DATA_WIDTH-1:0] top_val, top_val_next;
  logic signed [DATA_WIDTH-1:0] top_min, top_min_next;
  logic signed [DATA_WIDTH-1:0] top_max, top_max_next;
  logic [1:0] status_next;
  logic       out_load;
  logic       accept;

  logic signed [DATA_WIDTH-1:0] x, lo, hi;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  mmts_rsp_t     rsp_next;

  mmts_ram #(.DEPTH(DEPTH), .WIDTH(EW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data ({x, lo, hi}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    x  = DATA_WIDTH'(req_data.push_value);
    lo = ((fill != '0) && !(x <= top_min)) ? top_min : x;
    hi = ((fill != '0) && !(top_max <= x)) ? top_max : x;
    rd_addr = AW'(fill - FW'(2));

    state_next   = state;
    fill_next    = fill;
    top_val_next = top_val;
    top_min_next = top_min;
    top_max_next = top_max;
    status_next  = ST_OK;
    out_load     = 1'b0;
    wr_en        = 1'b0;

    if (state == S_LOAD) begin
      top_val_next = $signed(rd_data[EW-1 -: DATA_WIDTH]);
      top_min_next = $signed(rd_data[2*DATA_WIDTH-1 -: DATA_WIDTH]);
      top_max_next = $signed(rd_data[DATA_WIDTH-1:0]);
      out_load     = 1'b1;
      state_next   = S_IDLE;
    end else if (accept) begin
      out_load = 1'b1;
      unique case (req_data.opcode)
        OP_PUSH: begin
          if (fill == FW'(DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            fill_next    = fill + FW'(1);
            top_val_next = x;
            top_min_next = lo;
            top_max_next = hi;
          end
        end
        OP_POP: begin
          if (fill == '0) begin
            status_next = ST_EMPTY;
          end else begin
            fill_next = fill - FW'(1);
            // new top lives in RAM; wait for the read
            if (fill != FW'(1)) begin
              out_load   = 1'b0;
              state_next = S_LOAD;
            end
          end
        end
        default: begin
          // peek and the unused code: no change
        end
      endcase
    end

    rsp_next.is_empty    = (fill_next == '0);
    rsp_next.top_value   = rsp_next.is_empty ? -32'sd1 : 32'(top_val_next);
    rsp_next.min_value   = rsp_next.is_empty ? -32'sd1 : 32'(top_min_next);
    rsp_next.max_value   = rsp_next.is_empty ? -32'sd1 : 32'(top_max_next);
    rsp_next.entry_count = 7'(fill_next);
    rsp_next.status      = status_next;
  end

  // status of a deferred pop is always ok, so status_next covers both paths
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rsp_valid <= out_load || (rsp_valid && rsp_stall);
    end
    top_val <= top_val_next;
    top_min <= top_min_next;
    top_max <= top_max_next;
    if (out_load) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

@@ verif/min_max_tracking_stack_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_max_tracking_stack_tb
// Self-checking bench for the min/max tracking stack.
// ----------------------------------------------------------------------------
// A shadow stack predicts the top/min/max/empty/count/status response for
// every accepted request. Responses are checked in order. A short directed
// run covers empty and extreme cases, then push-biased, balanced or pop-biased
// random bursts run under several idle/stall mixes, with one long response hold-off.
// ----------------------------------------------------------------------------
module min_max_tracking_stack_tb;
  import mmts_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
  // opcode with no defined operation; the block treats it as a peek
  localparam logic [1:0] OP_SPARE = 2'd3;

  // shadow of the stack contents plus the queue of responses still owed
  class stack_tracker;
    logic signed [31:0] vals [DEPTH_DEF];
    logic signed [31:0] mins [DEPTH_DEF];
    logic signed [31:0] maxs [DEPTH_DEF];
    int unsigned held;
    mmts_rsp_t   due_views [$];
    int          errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_views.size();
    endfunction

    function void log_request(mmts_req_t r);
      mmts_rsp_t          e;
      logic signed [31:0] x;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      e        = '0;
      e.status = ST_OK;
      x        = r.push_value;
      case (r.opcode)
        OP_PUSH: begin
          if (held >= DEPTH_DEF) begin
            e.status = ST_FULL;
          end else begin
            lo = x;
            hi = x;
            if (held > 0) begin
              if (!(x <= mins[held-1])) lo = mins[held-1];
              if (!(x >= maxs[held-1])) hi = maxs[held-1];
            end
            vals[held] = x;
            mins[held] = lo;
            maxs[held] = hi;
            held++;
          end
        end
        OP_POP: begin
          if (held == 0) e.status = ST_EMPTY;
          else held--;
        end
        default: ; // peek and the unused code leave the stack alone
      endcase
      if (held == 0) begin
        e.top_value = -32'sd1;
        e.min_value = -32'sd1;
        e.max_value = -32'sd1;
        e.is_empty  = 1'b1;
      end else begin
        e.top_value = vals[held-1];
        e.min_value = mins[held-1];
        e.max_value = maxs[held-1];
        e.is_empty  = 1'b0;
      end
      e.entry_count = 7'(held);
      due_views.push_back(e);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("ERROR: %s", msg);
    endtask

    task check_response(mmts_rsp_t got);
      mmts_rsp_t e;
      if (due_views.size() == 0) begin
        report_mismatch($sformatf("response with no request pending: %h", got));
        return;
      end
      e = due_views.pop_front();
      if (got.top_value !== e.top_value)
        report_mismatch($sformatf("top_value got %h want %h", got.top_value, e.top_value));
      if (got.min_value !== e.min_value)
        report_mismatch($sformatf("min_value got %h want %h", got.min_value, e.min_value));
      if (got.max_value !== e.max_value)
        report_mismatch($sformatf("max_value got %h want %h", got.max_value, e.max_value));
      if (got.is_empty !== e.is_empty)
        report_mismatch($sformatf("is_empty got %b want %b", got.is_empty, e.is_empty));
      if (got.entry_count !== e.entry_count)
        report_mismatch($sformatf("entry_count got %0d want %0d",
                                  got.entry_count, e.entry_count));
      if (got.status !== e.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, e.status));
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  mmts_req_t req_data;
  logic      rsp_valid;
  logic      rsp_stall;
  mmts_rsp_t rsp_data;

  stack_tracker sb;
  int           idle_pct;
  int           stall_pct;
  logic         hold_rsp;
  int           cycle_count;

  min_max_tracking_stack DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL min_max_tracking_stack");
      $finish;
    end
  end

  // response side: check what was taken at this edge, then pick next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
    rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
  end

  task automatic issue(input logic [1:0] op, input logic signed [31:0] val);
    mmts_req_t r;
    r.opcode     = op;
    r.push_value = val;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.log_request(r);
  endtask

  // sender stops until every response owed has come back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom;
    if (sel < 75) return $signed($urandom_range(15)) - 8; // duplicates and ties
    case ($urandom_range(4))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  task automatic random_burst(input int count, input int push_pct);
    int unsigned sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 5)
        issue(OP_PEEK, $urandom);
      else if (sel < 10)
        issue(OP_SPARE, $urandom);
      else if ($urandom_range(99) < push_pct)
        issue(OP_PUSH, pick_value());
      else
        issue(OP_POP, $urandom);
    end
  endtask

  task automatic random_phase(input int quota);
    int sent;
    int len;
    int bias;
    sent = 0;
    while (sent < quota) begin
      len = $urandom_range(20, 120);
      if (len > quota - sent) len = quota - sent;
      case ($urandom_range(2))
        0:       bias = 15;
        1:       bias = 50;
        default: bias = 85;
      endcase
      random_burst(len, bias);
      sent += len;
    end
  endtask

  initial begin
    sb          = new();
    clk         = 1'b0;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req_data    = '0;
    rsp_stall   = 1'b0;
    hold_rsp    = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-stack reads, extremes, ties, underflow
    issue(OP_PEEK, $urandom);
    issue(OP_SPARE, $urandom);
    issue(OP_POP, $urandom);
    issue(OP_PUSH, VAL_MAX);
    issue(OP_PUSH, VAL_MIN);
    issue(OP_PUSH, -32'sd1);
    issue(OP_PUSH, 32'sd0);
    issue(OP_PUSH, VAL_MIN);
    issue(OP_PUSH, VAL_MAX);
    issue(OP_PEEK, 32'sh5a5a5a5a);
    issue(OP_SPARE, 32'sha5a5a5a5);
    for (int i = 0; i < 6; i++) issue(OP_POP, $urandom);
    issue(OP_POP, $urandom);
    issue(OP_PUSH, 32'sd5);
    issue(OP_POP, -32'sd1);
    issue(OP_PEEK, 32'sd0);
    drain();

    // long response hold-off that blocks the sender, then pushes run past full
    fork
      begin
        hold_rsp <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rsp <= 1'b0;
      end
    join_none
    for (int i = 0; i < 70; i++) issue(OP_PUSH, pick_value());
    random_burst(80, 10);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      random_phase(450);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS min_max_tracking_stack");
    end else begin
      $display("FAIL min_max_tracking_stack");
    end
    $finish;
  end

endmodule

@@ min_max_tracking_stack.f @@
design/mmts_pkg.sv
design/mmts_ram.sv
design/min_max_tracking_stack.sv
verif/min_max_tracking_stack_tb.sv
